>>> rtl/core/wkde_pkg.sv
package wkde_pkg;

  localparam int TIME_W    = 48;
  localparam int INDEX_W   = 12;
  localparam int DENSITY_W = 40;
  localparam int CONTRIB_W = 13;
  localparam int KVAL_W    = 17;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_LOC    = 2'd2,
    ACT_INDEX  = 2'd3
  } action_t;

  localparam logic [1:0] KERNEL_LAPLACE = 2'd0;
  localparam logic [1:0] KERNEL_GAUSS   = 2'd1;

  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_KIND  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HALF  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_HALF     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_TAU      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EXCLUDE_SELF = 3'd4;

  localparam logic [23:0] WINDOW_HALF_RST = 24'd1000;
  localparam logic [23:0] BOX_HALF_RST    = 24'd1000;
  localparam logic [31:0] INV_TAU_RST     = 32'd4294967;

  // exp(-1/256) in Q0.32
  localparam logic [31:0] EXP_STEP_Q32 = 32'd4278222805;

  localparam logic [KVAL_W-1:0]    ONE_Q16     = 17'd65536;
  localparam logic [DENSITY_W-1:0] DENSITY_MAX = '1;
  localparam logic [TIME_W-1:0]    TIME_MAX    = '1;

endpackage

>>> rtl/core/wkde_ram.sv
module wkde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/core/wkde_exp.sv
module wkde_exp #(
  parameter int EXP_ENTRIES = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  output logic                           ready,
  input  logic [$clog2(EXP_ENTRIES)-1:0] rd_addr,
  output logic [wkde_pkg::KVAL_W-1:0]    rd_data
);
  import wkde_pkg::*;

  localparam int TW = $clog2(EXP_ENTRIES);

  logic          busy;
  logic [TW-1:0] fill_addr;
  logic [32:0]   p;
  logic [64:0]   prod;
  logic [32:0]   p_next;
  logic [33:0]   entry_round;

  assign prod        = 65'(p) * 65'(EXP_STEP_Q32);
  assign p_next      = 33'((prod + 65'(64'd1 << 31)) >> 32);
  assign entry_round = (34'(p) + 34'd32768) >> 16;
  assign ready       = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b1;
      fill_addr <= '0;
      p         <= 33'(64'd1 << 32);
    end else if (busy) begin
      p         <= p_next;
      fill_addr <= fill_addr + 1'b1;
      if (fill_addr == TW'(EXP_ENTRIES - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  wkde_ram #(
    .WIDTH(KVAL_W),
    .DEPTH(EXP_ENTRIES)
  ) u_table (
    .clk    (clk),
    .wr_en  (busy),
    .wr_addr(fill_addr),
    .wr_data(entry_round[KVAL_W-1:0]),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

endmodule

>>> rtl/core/windowed_kernel_density_engine.sv
// Kernel density over a sorted event store. Append and clear transfers are handled in S_IDLE.
// A query starts from S_IDLE (an index query first reads its event in S_LOC), then walks its
// window pointers forward through S_LOW_RD, S_LOW_CHK, S_HIGH_RD and S_HIGH_CHK, then reads
// every event in the window through the single event memory read port: a skipped event is
// dropped after its read, the box kernel compares in S_SUM_D, and the Laplace or Gaussian kernel
// goes on through S_KQ (square, Gaussian only), S_PP (split 48x32 product) and S_IX (exp table
// read). S_SUM_RD ends the walk and S_FIN presents the result, which waits while the previous
// result is still held. After reset the exp table is computed into its memory, during which no item is accepted.
module windowed_kernel_density_engine #(
  parameter int EVENT_DEPTH = 4096,
  parameter int EXP_ENTRIES = 4096
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [63:0]                        s_axis_tdata,  // time_value, event_index
  input  logic [1:0]                         s_axis_tuser,  // action
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [55:0]                        m_axis_tdata,  // density, contributors
  output logic                               m_axis_tuser,  // saturated
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [wkde_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wkde_pkg::CFG_DAT_W-1:0]     cfg_data
);
  import wkde_pkg::*;

  localparam int AW = $clog2(EVENT_DEPTH);
  localparam int CW = $clog2(EVENT_DEPTH + 1);
  localparam int TW = $clog2(EXP_ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE, S_LOC, S_LOW_RD, S_LOW_CHK, S_HIGH_RD, S_HIGH_CHK,
    S_SUM_RD, S_SUM_D, S_KQ, S_PP, S_IX, S_ACC, S_FIN
  } state_t;

  state_t state;

  logic [1:0]  kernel_kind;
  logic [23:0] window_half;
  logic [23:0] box_half_width;
  logic [31:0] inv_tau;
  logic        exclude_self;

  logic [CW-1:0] event_count;
  logic [CW-1:0] window_low;
  logic [CW-1:0] window_high;
  logic [CW-1:0] pos;

  logic [TIME_W-1:0]    loc;
  logic                 by_index;
  logic [INDEX_W-1:0]   ei;
  logic [TIME_W-1:0]    dabs;
  logic [TIME_W-1:0]    q;
  logic [63:0]          p_lo;
  logic [47:0]          p_hi;
  logic [KVAL_W-1:0]    kfix;
  logic                 use_tbl;
  logic [DENSITY_W-1:0] sum;
  logic [CW-1:0]        num;
  logic                 sat;

  logic                 in_fire;
  action_t              action;
  logic [TIME_W-1:0]    in_time;
  logic [INDEX_W-1:0]   in_index;
  logic                 wr_en;
  logic [AW-1:0]        rd_addr;
  logic [TIME_W-1:0]    rd_data;
  logic                 tbl_ready;
  logic [TW-1:0]        tbl_addr;
  logic [KVAL_W-1:0]    tbl_data;
  logic [TIME_W-1:0]    dabs_c;
  logic                 skip;
  logic [79:0]          prod;
  logic [55:0]          tbl_idx;
  logic                 idx_over;
  logic [KVAL_W-1:0]    kval;
  logic [DENSITY_W:0]   sum_c;
  logic                 is_box;

  assign action   = action_t'(s_axis_tuser);
  assign in_time  = s_axis_tdata[TIME_W-1:0];
  assign in_index = s_axis_tdata[TIME_W +: INDEX_W];

  assign s_axis_tready = (state == S_IDLE) && tbl_ready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  assign wr_en  = in_fire && (action == ACT_APPEND) && (event_count < CW'(EVENT_DEPTH));
  assign dabs_c = (rd_data >= loc) ? rd_data - loc : loc - rd_data;
  assign skip   = by_index ? (exclude_self && (32'(pos) == 32'(ei))) : (rd_data == loc);
  assign is_box = (kernel_kind != KERNEL_LAPLACE) && (kernel_kind != KERNEL_GAUSS);

  assign prod     = 80'(p_lo) + (80'(p_hi) << 32);
  assign tbl_idx  = prod[79:24];
  assign idx_over = tbl_idx >= 56'(EXP_ENTRIES);
  assign tbl_addr = tbl_idx[TW-1:0];
  assign kval     = use_tbl ? tbl_data : kfix;
  assign sum_c    = 41'(sum) + 41'(kval);

  always_comb begin
    rd_addr = '0;
    case (state)
      S_IDLE:    rd_addr = AW'(in_index);
      S_LOW_RD:  rd_addr = window_low[AW-1:0];
      S_HIGH_RD: rd_addr = window_high[AW-1:0];
      S_SUM_RD:  rd_addr = pos[AW-1:0];
      default:   rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_kind    <= KERNEL_LAPLACE;
      window_half    <= WINDOW_HALF_RST;
      box_half_width <= BOX_HALF_RST;
      inv_tau        <= INV_TAU_RST;
      exclude_self   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KERNEL_KIND:  kernel_kind    <= cfg_data[1:0];
        REG_WINDOW_HALF:  window_half    <= cfg_data[23:0];
        REG_BOX_HALF:     box_half_width <= cfg_data[23:0];
        REG_INV_TAU:      inv_tau        <= cfg_data;
        REG_EXCLUDE_SELF: exclude_self   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      event_count   <= '0;
      window_low    <= '0;
      window_high   <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tready && (state != S_FIN)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            by_index <= (action == ACT_INDEX);
            ei       <= in_index;
            loc      <= in_time;
            sum      <= '0;
            num      <= '0;
            sat      <= (action == ACT_INDEX) && (32'(in_index) >= 32'(event_count));
            case (action)
              ACT_CLEAR: begin
                event_count <= '0;
                window_low  <= '0;
                window_high <= '0;
              end
              ACT_APPEND: begin
                if (wr_en) begin
                  event_count <= event_count + 1'b1;
                end
              end
              ACT_LOC: state <= S_LOW_RD;
              ACT_INDEX: begin
                if (32'(in_index) >= 32'(event_count)) begin
                  state <= S_FIN;
                end else begin
                  state <= S_LOC;
                end
              end
              default: ;
            endcase
          end
        end
        S_LOC: begin
          loc   <= rd_data;
          state <= S_LOW_RD;
        end
        S_LOW_RD: state <= (window_low < event_count) ? S_LOW_CHK : S_HIGH_RD;
        S_LOW_CHK: begin
          if (49'(rd_data) + 49'(window_half) < 49'(loc)) begin
            window_low <= window_low + 1'b1;
            state      <= S_LOW_RD;
          end else begin
            state <= S_HIGH_RD;
          end
        end
        S_HIGH_RD: begin
          if (window_high < event_count) begin
            state <= S_HIGH_CHK;
          end else begin
            pos   <= window_low;
            state <= S_SUM_RD;
          end
        end
        S_HIGH_CHK: begin
          if (49'(rd_data) < 49'(loc) + 49'(window_half)) begin
            window_high <= window_high + 1'b1;
            state       <= S_HIGH_RD;
          end else begin
            pos   <= window_low;
            state <= S_SUM_RD;
          end
        end
        S_SUM_RD: begin
          state <= (pos < window_high && pos < event_count) ? S_SUM_D : S_FIN;
        end
        S_SUM_D: begin
          dabs <= dabs_c;
          if (skip) begin
            pos   <= pos + 1'b1;
            state <= S_SUM_RD;
          end else if (is_box) begin
            kfix    <= (dabs_c < 48'(box_half_width)) ? ONE_Q16 : '0;
            use_tbl <= 1'b0;
            state   <= S_ACC;
          end else begin
            state <= S_KQ;
          end
        end
        S_KQ: begin
          if (kernel_kind == KERNEL_GAUSS) begin
            q <= (dabs[47:24] != '0) ? TIME_MAX : 48'(dabs[23:0]) * 48'(dabs[23:0]);
          end else begin
            q <= dabs;
          end
          state <= S_PP;
        end
        S_PP: begin
          p_lo  <= 64'(q[31:0]) * 64'(inv_tau);
          p_hi  <= 48'(q[47:32]) * 48'(inv_tau);
          state <= S_IX;
        end
        S_IX: begin
          use_tbl <= !idx_over;
          kfix    <= '0;
          state   <= S_ACC;
        end
        S_ACC: begin
          if (sum_c > 41'(DENSITY_MAX)) begin
            sum <= DENSITY_MAX;
            sat <= 1'b1;
          end else begin
            sum <= sum_c[DENSITY_W-1:0];
          end
          num   <= num + 1'b1;
          pos   <= pos + 1'b1;
          state <= S_SUM_RD;
        end
        S_FIN: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {3'b000, 13'(num), sum};
            m_axis_tuser  <= sat;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  wkde_ram #(
    .WIDTH(TIME_W),
    .DEPTH(EVENT_DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(event_count[AW-1:0]),
    .wr_data(in_time),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  wkde_exp #(
    .EXP_ENTRIES(EXP_ENTRIES)
  ) u_exp (
    .clk    (clk),
    .rst    (rst),
    .ready  (tbl_ready),
    .rd_addr(tbl_addr),
    .rd_data(tbl_data)
  );

endmodule

>>> bench/tb_windowed_kernel_density_engine.sv
`timescale 1ns / 100ps

module tb_windowed_kernel_density_engine;
  import wkde_pkg::*;

  localparam logic [1:0] KERNEL_BOX     = 2'd2;
  localparam logic [1:0] KERNEL_BOX_ALT = 2'd3;
  localparam int STORE_DEPTH = 4096;
  localparam int TABLE_SIZE  = 4096;
  localparam int ITEM_GOAL   = 1750;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic                 sat;
    logic [CONTRIB_W-1:0] contrib;
    logic [DENSITY_W-1:0] density;
  } density_result_t;

  class density_scoreboard;
    logic [TIME_W-1:0]   store [STORE_DEPTH];
    int unsigned         count, wlo, whi;
    logic [KVAL_W-1:0]   exp_tab [TABLE_SIZE];
    logic [1:0]          kind;
    logic [23:0]         whalf, bhalf;
    logic [31:0]         itau;
    logic                excl;
    density_result_t     expected_q[$];
    int                  errors;

    function new();
      longint unsigned term, sum, r32, p;
      term = 64'd1 << 62;
      sum = term;
      for (int k = 1; k <= 10; k++) begin
        term = term / (64'd256 * k);
        if (k % 2) sum -= term; else sum += term;
      end
      r32 = (sum + (64'd1 << 29)) >> 30;
      p = 64'd1 << 32;
      for (int i = 0; i < TABLE_SIZE; i++) begin
        exp_tab[i] = KVAL_W'((p + 64'd32768) >> 16);
        p = (p * r32 + (64'd1 << 31)) >> 32;
      end
      count = 0; wlo = 0; whi = 0;
      kind = KERNEL_LAPLACE;
      whalf = WINDOW_HALF_RST;
      bhalf = BOX_HALF_RST;
      itau = INV_TAU_RST;
      excl = 1'b0;
      errors = 0;
    endfunction

    function void report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
      case (idx)
        REG_KERNEL_KIND:  kind = val[1:0];
        REG_WINDOW_HALF:  whalf = val[23:0];
        REG_BOX_HALF:     bhalf = val[23:0];
        REG_INV_TAU:      itau = val;
        REG_EXCLUDE_SELF: excl = val[0];
        default: ;
      endcase
    endfunction

    function longint unsigned exp_of(longint unsigned q);
      longint unsigned a, b, idx;
      a = q * longint'(itau[31:16]);
      b = q * longint'(itau[15:0]);
      idx = (a >> 8) + (b >> 24) + ((((a & 64'hFF) << 16) + (b & 64'hFFFFFF)) >> 24);
      if (idx >= TABLE_SIZE) return 64'd0;
      return longint'(exp_tab[idx]);
    endfunction

    function longint unsigned kernel_of(longint unsigned d);
      if (kind == KERNEL_LAPLACE) return exp_of(d);
      if (kind == KERNEL_GAUSS) return exp_of(d >= (64'd1 << 24) ? 64'hFFFFFFFFFFFF : d * d);
      return (d < longint'(bhalf)) ? 64'd65536 : 64'd0;
    endfunction

    function void note_input(action_t act, logic [TIME_W-1:0] tv, logic [INDEX_W-1:0] ei);
      longint unsigned loc, t, d, sum;
      int unsigned n;
      logic sat, by_index;
      density_result_t r;
      case (act)
        ACT_CLEAR: begin
          count = 0; wlo = 0; whi = 0;
        end
        ACT_APPEND: begin
          if (count < STORE_DEPTH) begin
            store[count] = tv;
            count++;
          end
        end
        default: begin
          by_index = (act == ACT_INDEX);
          if (by_index && ei >= count) begin
            r.density = '0; r.contrib = '0; r.sat = 1'b1;
            expected_q.push_back(r);
            return;
          end
          loc = by_index ? longint'(store[ei]) : longint'(tv);
          while (wlo < count && longint'(store[wlo]) + longint'(whalf) < loc) wlo++;
          while (whi < count && longint'(store[whi]) < loc + longint'(whalf)) whi++;
          sum = 0; n = 0; sat = 1'b0;
          for (int unsigned i = wlo; i < whi && i < count; i++) begin
            t = longint'(store[i]);
            if (by_index) begin
              if (excl && i == ei) continue;
            end else if (t == loc) begin
              continue;
            end
            d = (t >= loc) ? t - loc : loc - t;
            sum += kernel_of(d);
            if (sum > 64'hFFFFFFFFFF) begin
              sum = 64'hFFFFFFFFFF;
              sat = 1'b1;
            end
            n++;
          end
          r.density = sum[DENSITY_W-1:0];
          r.contrib = n[CONTRIB_W-1:0];
          r.sat = sat;
          expected_q.push_back(r);
        end
      endcase
    endfunction

    function void check_result(density_result_t got);
      density_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result density=%0h", got.density));
        return;
      end
      want = expected_q.pop_front();
      if (got.density !== want.density)
        report($sformatf("density %0h, want %0h", got.density, want.density));
      if (got.contrib !== want.contrib)
        report($sformatf("contributors %0d, want %0d", got.contrib, want.contrib));
      if (got.sat !== want.sat)
        report($sformatf("saturated %0b, want %0b", got.sat, want.sat));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [63:0]          s_axis_tdata = '0;  // time_value, event_index
  logic [1:0]           s_axis_tuser = '0;  // action
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [55:0]          m_axis_tdata;       // density, contributors
  logic                 m_axis_tuser;       // saturated
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  density_scoreboard sb = new();
  bit     calm = 1'b0;
  int     items_sent = 0;
  longint cycles = 0;

  windowed_kernel_density_engine uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result({m_axis_tuser, m_axis_tdata[52:40], m_axis_tdata[39:0]});
    m_axis_tready <= calm || ($urandom_range(99) >= 22);
  end

  function automatic logic [TIME_W-1:0] rand_time();
    return TIME_W'({$urandom, $urandom});
  endfunction

  task automatic send_item(action_t act, logic [TIME_W-1:0] tv, logic [INDEX_W-1:0] ei);
    int gap;
    calm = (items_sent >= 700 && items_sent < 1000);
    if (!calm && $urandom_range(99) < 22) begin
      s_axis_tvalid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= {4'b0, ei, tv};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_input(act, tv, ei);
    items_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic apply_setting(logic [1:0] kind, logic [23:0] wh, logic [23:0] bh,
                               logic [31:0] itau, logic ex);
    logic [31:0] vals [5];
    vals[0] = 32'(kind); vals[1] = 32'(wh); vals[2] = 32'(bh); vals[3] = itau;
    vals[4] = 32'(ex);
    drain();
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.set_reg(CFG_IDX_W'(i), vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(int unsigned gap_max, int n_ev, int n_q);
    logic [TIME_W-1:0] times[$];
    logic [TIME_W-1:0] t, loc;
    int next_idx, r;
    send_item(ACT_CLEAR, rand_time(), INDEX_W'($urandom));
    t = rand_time() >> 1;
    for (int i = 0; i < n_ev; i++) begin
      t += $urandom_range(0, gap_max);
      times.push_back(t);
      send_item(ACT_APPEND, t, INDEX_W'($urandom));
    end
    loc = times[0] - (times[0] > 64'd100 ? $urandom_range(0, 100) : 0);
    next_idx = 0;
    for (int q = 0; q < n_q; q++) begin
      r = $urandom_range(99);
      if (r < 10) begin
        send_item(action_t'($urandom_range(3)), rand_time(), INDEX_W'($urandom));
      end else if (r < 45) begin
        while (next_idx < n_ev && times[next_idx] < loc) next_idx++;
        if ($urandom_range(1) && next_idx < n_ev) loc = times[next_idx];
        else loc += $urandom_range(0, gap_max * 2 + 1);
        send_item(ACT_LOC, loc, INDEX_W'($urandom));
      end else begin
        while (next_idx < n_ev && times[next_idx] < loc) next_idx++;
        if ($urandom_range(9) == 0) next_idx += $urandom_range(0, 2);
        if (next_idx < n_ev) loc = times[next_idx];
        send_item(ACT_INDEX, rand_time(), INDEX_W'(next_idx));
      end
    end
  endtask

  initial begin
    int unsigned scales [5] = '{0, 16, 1000, 65536, 1 << 24};
    int p;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_item(ACT_CLEAR, '0, '0);
    send_item(ACT_APPEND, 48'd0, '0);
    send_item(ACT_APPEND, 48'd5, '0);
    send_item(ACT_APPEND, 48'd5, '0);
    send_item(ACT_APPEND, 48'd1500, '0);
    send_item(ACT_APPEND, 48'd2000, '0);
    send_item(ACT_LOC, 48'd5, '0);
    send_item(ACT_INDEX, '0, 12'd1);
    send_item(ACT_INDEX, '0, 12'd9);
    send_item(ACT_LOC, 48'd1000, '0);
    send_item(ACT_LOC, 48'd0, '0);
    send_item(ACT_LOC, TIME_MAX, 12'd4095);
    send_item(ACT_APPEND, TIME_MAX, 12'd4095);
    send_item(ACT_INDEX, TIME_MAX, 12'd5);
    send_item(ACT_INDEX, '0, 12'd2);

    apply_setting(KERNEL_GAUSS, 24'd40, 24'd0, 32'hFFFFFFFF, 1'b1);
    send_item(ACT_CLEAR, '0, '0);
    send_item(ACT_APPEND, 48'd10, '0);
    send_item(ACT_APPEND, 48'd20, '0);
    send_item(ACT_APPEND, 48'd30, '0);
    send_item(ACT_INDEX, '0, 12'd1);
    send_item(ACT_LOC, 48'd20, '0);

    apply_setting(KERNEL_BOX_ALT, 24'hFFFFFF, 24'd15, 32'd0, 1'b0);
    send_item(ACT_INDEX, '0, 12'd1);
    send_item(ACT_LOC, 48'd25, '0);

    p = 0;
    while (items_sent < ITEM_GOAL) begin
      case (p % 8)
        0: apply_setting(KERNEL_LAPLACE, WINDOW_HALF_RST, BOX_HALF_RST, INV_TAU_RST, 1'b0);
        1: apply_setting(KERNEL_LAPLACE, 24'hFFFFFF, 24'd0, 32'hFFFFFFFF, 1'b1);
        2: apply_setting(KERNEL_GAUSS, 24'd0, 24'hFFFFFF, 32'd0, 1'b0);
        3: apply_setting(KERNEL_BOX, 24'd5000, 24'd2000, $urandom, 1'b1);
        4: apply_setting(KERNEL_BOX_ALT, 24'($urandom), 24'($urandom), $urandom, 1'b0);
        default: apply_setting(2'($urandom_range(3)), 24'($urandom_range(0, 1 << 20)),
                               24'($urandom), $urandom, 1'($urandom_range(1)));
      endcase
      run_phase(scales[$urandom_range(4)], $urandom_range(1, 40), $urandom_range(10, 40));
      p++;
    end

    drain();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/wkde_pkg.sv
rtl/core/wkde_ram.sv
rtl/core/wkde_exp.sv
rtl/core/windowed_kernel_density_engine.sv
bench/tb_windowed_kernel_density_engine.sv
